>>> rtl/bmd_pkg.sv
// bmd_pkg: shared constants and types of the mip downsampler
// used by box_filter_mip_downsample; no dependencies
`timescale 1ns / 1ps

package bmd_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int CFG_W         = 13;
    localparam int CFG_INDEX_W   = 2;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_W      = 13;
    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 4;
    localparam int PAIR_W        = CHAN_W + 1;
    localparam int LINE_W        = NUM_CHAN * PAIR_W;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd256;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    // per-word control decoded from the raster position
    typedef struct packed {
        logic hold;
        logic line_rd;
        logic line_wr;
        logic emit;
        logic quad;
        logic last;
    } step_ctrl_t;

endpackage

>>> rtl/box_filter_mip_downsample.sv
// box_filter_mip_downsample: 2x2 box filter producing the next mip level
// depends on bmd_pkg and bmd_ram
`timescale 1ns / 1ps

// RGBA8 words enter in raster order on the input channel (in_valid / in_stall)
// and the reduced image leaves in raster order on the output channel
// (out_valid / out_stall). One input word is taken every clock while in_stall
// is low; a result appears in the cycle after the word that completes its 2x2
// block or pair; last_of_image marks the final result of each reduced image.
// image_width and image_height are written through cfg_wr_en / cfg_index /
// cfg_data while the block is idle; either write restarts the image at (0,0).
// Even-row pair sums sit in a line RAM of MAX_WIDTH/2 words of four 9-bit
// sums; the odd row fetches its entry on the even pixel of each pair, so the
// sustained rate is one word per clock, limited by the single output register.
// When the receiver stalls with a result pending, in_stall rises in the same
// cycle and the pending result holds until taken.
// Reset clears the counters, the held pixel and the output valid, and loads
// a 256 x 256 image size; the line RAM needs no clearing since every entry
// is written on an even row before the odd row reads it.
module box_filter_mip_downsample #(
    parameter int MAX_WIDTH = bmd_pkg::DEF_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bmd_pkg::CHAN_W-1:0]      red_in,
    input  logic [bmd_pkg::CHAN_W-1:0]      green_in,
    input  logic [bmd_pkg::CHAN_W-1:0]      blue_in,
    input  logic [bmd_pkg::CHAN_W-1:0]      alpha_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bmd_pkg::CHAN_W-1:0]      red_out,
    output logic [bmd_pkg::CHAN_W-1:0]      green_out,
    output logic [bmd_pkg::CHAN_W-1:0]      blue_out,
    output logic [bmd_pkg::CHAN_W-1:0]      alpha_out,
    output logic                            last_of_image,
    input  logic                            cfg_wr_en,
    input  logic [bmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bmd_pkg::CFG_W-1:0]       cfg_data
);

    import bmd_pkg::*;

    localparam int XW         = $clog2(MAX_WIDTH + 1);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int EW         = (XW > CFG_W) ? XW : CFG_W;

    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [XW-1:0]       col_reg;
    logic [XW-1:0]       col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    pixel_t              held_reg;
    logic                out_valid_reg;
    pixel_t              out_pix_reg;
    logic                out_last_reg;

    logic [EW-1:0]       width_ext;
    logic [XW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [XW-1:0]       x_end;
    logic [HEIGHT_W-1:0] y_end;
    logic [HEIGHT_W-1:0] row_ext;
    logic                x_in;
    logic                y_in;
    logic                x_last;
    logic                y_last;
    logic                w_one;
    logic                h_one;
    logic                in_acc;
    step_ctrl_t          ctrl;

    pixel_t              pix;
    pixel_t              res_pix;
    logic [LINE_W-1:0]   pair_packed;
    logic [LINE_W-1:0]   line_rd_data;
    logic [PAIR_W-1:0]   pair_sum [NUM_CHAN];
    logic [PAIR_W:0]     quad_sum [NUM_CHAN];

    assign pix      = {alpha_in, blue_in, green_in, red_in};
    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    // effective image size
    assign width_ext = EW'(width_reg);

    always_comb
    begin
        priority if (width_ext == '0)
        begin
            eff_w = XW'(1);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            eff_w = XW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = XW'(width_ext);
        end

        priority if (height_reg == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
        else if (height_reg > HEIGHT_W'(HEIGHT_LIMIT))
        begin
            eff_h = HEIGHT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign x_end   = {eff_w[XW-1:1], 1'b0};
    assign y_end   = {eff_h[HEIGHT_W-1:1], 1'b0};
    assign row_ext = {1'b0, row_reg};
    assign x_in    = col_reg < x_end;
    assign y_in    = row_ext < y_end;
    assign x_last  = col_reg == (x_end - XW'(1));
    assign y_last  = row_ext == (y_end - HEIGHT_W'(1));
    assign w_one   = eff_w == XW'(1);
    assign h_one   = eff_h == HEIGHT_W'(1);

    // position decode
    always_comb
    begin
        ctrl = '0;
        priority if (!in_acc || (w_one && h_one))
        begin
            ctrl = '0;
        end
        else if (w_one || h_one)
        begin
            if (w_one ? y_in : x_in)
            begin
                if (!(w_one ? row_reg[0] : col_reg[0]))
                begin
                    ctrl.hold = 1'b1;
                end
                else
                begin
                    ctrl.emit = 1'b1;
                    ctrl.last = w_one ? y_last : x_last;
                end
            end
        end
        else if (x_in && y_in)
        begin
            priority if (!col_reg[0])
            begin
                ctrl.hold    = 1'b1;
                ctrl.line_rd = row_reg[0];
            end
            else if (!row_reg[0])
            begin
                ctrl.line_wr = 1'b1;
            end
            else
            begin
                ctrl.emit = 1'b1;
                ctrl.quad = 1'b1;
                ctrl.last = x_last && y_last;
            end
        end
        else
        begin
            // trailing odd column or row
            ctrl = '0;
        end
    end

    // channel arithmetic
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            pair_sum[c] = {1'b0, held_reg[c]} + {1'b0, pix[c]};
            quad_sum[c] = {1'b0, line_rd_data[c*PAIR_W +: PAIR_W]} + {1'b0, pair_sum[c]};
            pair_packed[c*PAIR_W +: PAIR_W] = pair_sum[c];
            res_pix[c] = ctrl.quad ? quad_sum[c][PAIR_W:2] : pair_sum[c][PAIR_W-1:1];
        end
    end

    bmd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ctrl.line_wr),
        .wr_addr (col_reg[AW:1]),
        .wr_data (pair_packed),
        .rd_en   (ctrl.line_rd),
        .rd_addr (col_reg[AW:1]),
        .rd_data (line_rd_data)
    );

    // raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (col_reg == (eff_w - XW'(1)))
            begin
                col_next = '0;
                row_next = (row_ext == (eff_h - HEIGHT_W'(1))) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                        col_reg <= col_next;
                        row_reg <= row_next;
                    end
                endcase
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (ctrl.hold)
            begin
                held_reg <= pix;
            end

            if (in_acc)
            begin
                out_valid_reg <= ctrl.emit;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_pix_reg  <= res_pix;
            out_last_reg <= ctrl.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = out_pix_reg[0];
    assign green_out     = out_pix_reg[1];
    assign blue_out      = out_pix_reg[2];
    assign alpha_out     = out_pix_reg[3];
    assign last_of_image = out_last_reg;

    // checks
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < eff_w)
        else $error("column counter beyond image width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_ext < eff_h)
        else $error("row counter beyond image height");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_acc))
        else $error("result appeared without an accepted word");

    a_line_ports: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.line_rd && ctrl.line_wr) && !(ctrl.emit && ctrl.hold))
        else $error("conflicting line buffer or pixel actions");

endmodule

>>> rtl/bmd_ram.sv
// bmd_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bmd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
